// ===== rtl/swu_pkg.sv =====
// Shared types and constants for the STDP weight update unit.
// Used by swu_ctrl, swu_datapath and stdp_weight_update_unit; no dependencies.
`default_nettype none
package swu_pkg;

  // Fixed field widths
  localparam int SPIKE_TIME_W = 32;
  localparam int GAIN_W       = 16;
  localparam int TAU_W        = 16;
  localparam int WIN_W        = 20;
  localparam int CEIL_W       = 24;
  localparam int TX_W         = 25;
  localparam int WNOW_W       = 24;
  localparam int MODE_W       = 2;

  // Decay table entries: Q0.16 up to 1.0, so 17 bits
  localparam int E_W          = 17;
  // Table build accumulator: Q0.32 up to 1.0
  localparam int ACC_W        = 33;
  localparam logic [31:0] DECAY_STEP_Q32 = 32'd4278222805;

  // Divider: numerator is a 20-bit gap shifted up by 8
  localparam int NUM_W        = WIN_W + 8;
  localparam int DIV_CNT_W    = 5;

  // Configuration port
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 24;

  localparam logic [CFG_IDX_W-1:0] REG_BOUND_MODE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POT_GAIN    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEP_GAIN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_POT_TAU     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DEP_TAU     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_LOW     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_HIGH    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_CEILING     = 3'd7;

  // Bound modes; any other code acts as hard clamp
  localparam logic [MODE_W-1:0] MODE_UNBOUND = 2'd0;
  localparam logic [MODE_W-1:0] MODE_HARD    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_AGILE   = 2'd2;

  // Event kind in tuser
  localparam logic OP_PRE  = 1'b0;
  localparam logic OP_POST = 1'b1;

  // Controller to datapath
  typedef struct packed {
    logic fill_a;    // table build, low partial product
    logic fill_b;    // table build, combine and write entry
    logic load;      // take input word
    logic div_step;  // one quotient bit
    logic rom_rd;    // read decay entry
    logic gain_mul;  // dw = gain * entry
    logic dw_zero;   // no change for this event
    logic w_mul;     // weight * (1 - dw)
    logic commit;    // update state and load output register
  } swu_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic fill_last;
    logic needs_change;
    logic q_small;
  } swu_stat_t;

endpackage
`default_nettype wire

// ===== rtl/swu_ctrl.sv =====
// Sequencer for the STDP weight update unit: table build, divide, lookup, apply.
// Depends on swu_pkg.
`default_nettype none
module swu_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  input  wire swu_pkg::swu_stat_t stat,
  output swu_pkg::swu_cmd_t      cmd
);

  typedef enum logic [3:0] {
    S_FILL_A, S_FILL_B, S_IDLE, S_CHECK, S_DIV, S_ROM, S_GAIN, S_WMUL, S_APPLY
  } state_t;

  state_t                           state_r, state_nxt;
  logic [swu_pkg::DIV_CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                             ovalid_r, ovalid_nxt;
  logic                             out_free;

  assign out_free   = !ovalid_r || out_tready;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = ovalid_r;

  // Next state and commands
  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    ovalid_nxt = ovalid_r;
    cmd        = '0;
    if (ovalid_r && out_tready) begin
      ovalid_nxt = 1'b0;
    end
    case (state_r)
      S_FILL_A: begin
        cmd.fill_a = 1'b1;
        state_nxt  = S_FILL_B;
      end
      S_FILL_B: begin
        cmd.fill_b = 1'b1;
        state_nxt  = stat.fill_last ? S_IDLE : S_FILL_A;
      end
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        cnt_nxt = '0;
        if (stat.needs_change) begin
          state_nxt = S_DIV;
        end else begin
          cmd.dw_zero = 1'b1;
          state_nxt   = S_WMUL;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == swu_pkg::DIV_CNT_W'(swu_pkg::NUM_W - 1)) begin
          state_nxt = S_ROM;
        end
      end
      S_ROM: begin
        if (stat.q_small) begin
          cmd.rom_rd = 1'b1;
          state_nxt  = S_GAIN;
        end else begin
          cmd.dw_zero = 1'b1;
          state_nxt   = S_WMUL;
        end
      end
      S_GAIN: begin
        cmd.gain_mul = 1'b1;
        state_nxt    = S_WMUL;
      end
      S_WMUL: begin
        cmd.w_mul = 1'b1;
        state_nxt = S_APPLY;
      end
      S_APPLY: begin
        if (out_free) begin
          cmd.commit = 1'b1;
          ovalid_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_FILL_A;
      cnt_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/swu_datapath.sv =====
// Datapath of the STDP weight update unit: config registers, decay table memory,
// gap divider, multipliers, weight update and output register. Depends on swu_pkg.
`default_nettype none
module swu_datapath #(
  parameter int TIME_BITS       = 32,
  parameter int WEIGHT_BITS     = 24,
  parameter int EXP_TABLE_DEPTH = 4096
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_wr_en,
  input  wire logic [swu_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [swu_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  wire logic [swu_pkg::SPIKE_TIME_W-1:0]  in_spike_time,
  input  wire logic                              in_op,
  input  wire swu_pkg::swu_cmd_t                 cmd,
  output swu_pkg::swu_stat_t                     stat,
  output logic [swu_pkg::TX_W-1:0]               out_transmitted,
  output logic [swu_pkg::WNOW_W-1:0]             out_weight_now
);

  localparam int AW  = $clog2(EXP_TABLE_DEPTH);
  localparam int CW  = (TIME_BITS > swu_pkg::WIN_W) ? TIME_BITS : swu_pkg::WIN_W;
  localparam int EW  = ((WEIGHT_BITS > swu_pkg::CEIL_W) ? WEIGHT_BITS : swu_pkg::CEIL_W) + 1;
  localparam int TXW = EW + 1;
  localparam int PW  = WEIGHT_BITS + swu_pkg::E_W;

  // Configuration registers
  logic [swu_pkg::MODE_W-1:0]  mode_r;
  logic [swu_pkg::GAIN_W-1:0]  pgain_r, dgain_r;
  logic [swu_pkg::TAU_W-1:0]   ptau_r, dtau_r;
  logic [swu_pkg::WIN_W-1:0]   wlow_r, whigh_r;
  logic [swu_pkg::CEIL_W-1:0]  ceil_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= swu_pkg::MODE_HARD;
      pgain_r <= 16'd19661;
      dgain_r <= 16'd20349;
      ptau_r  <= 16'd20;
      dtau_r  <= 16'd20;
      wlow_r  <= 20'd2;
      whigh_r <= 20'd60;
      ceil_r  <= 24'd65536;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        swu_pkg::REG_BOUND_MODE: mode_r  <= cfg_wdata[swu_pkg::MODE_W-1:0];
        swu_pkg::REG_POT_GAIN:   pgain_r <= cfg_wdata[swu_pkg::GAIN_W-1:0];
        swu_pkg::REG_DEP_GAIN:   dgain_r <= cfg_wdata[swu_pkg::GAIN_W-1:0];
        swu_pkg::REG_POT_TAU:    ptau_r  <= cfg_wdata[swu_pkg::TAU_W-1:0];
        swu_pkg::REG_DEP_TAU:    dtau_r  <= cfg_wdata[swu_pkg::TAU_W-1:0];
        swu_pkg::REG_WIN_LOW:    wlow_r  <= cfg_wdata[swu_pkg::WIN_W-1:0];
        swu_pkg::REG_WIN_HIGH:   whigh_r <= cfg_wdata[swu_pkg::WIN_W-1:0];
        swu_pkg::REG_CEILING:    ceil_r  <= cfg_wdata[swu_pkg::CEIL_W-1:0];
        default: ;
      endcase
    end
  end

  // Decay table build: acc <- acc * step >> 32, split over the fill_a and fill_b steps
  logic [swu_pkg::ACC_W-1:0] acc_r;
  logic [47:0]               plo_r;
  logic [AW-1:0]             fidx_r;
  logic [48:0]               phi;
  logic [swu_pkg::ACC_W:0]   acc_rnd;
  logic [swu_pkg::E_W-1:0]   fill_e;

  assign phi     = (49'(acc_r[32:16]) * 49'(swu_pkg::DECAY_STEP_Q32)) + 49'(plo_r[47:16]);
  assign acc_rnd = {1'b0, acc_r} + 34'd32768;
  assign fill_e  = acc_rnd[32:16];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= 33'h1_0000_0000;
      fidx_r <= '0;
    end else if (cmd.fill_b) begin
      acc_r  <= phi[48:16];
      fidx_r <= fidx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fill_a) begin
      plo_r <= 48'(acc_r[15:0]) * 48'(swu_pkg::DECAY_STEP_Q32);
    end
  end

  // Decay table memory, one write port and one registered read port
  logic [swu_pkg::E_W-1:0] rom_mem [EXP_TABLE_DEPTH];
  logic [swu_pkg::E_W-1:0] rom_q_r;
  logic [swu_pkg::NUM_W-1:0] num_r;

  always_ff @(posedge clk) begin
    if (cmd.fill_b) begin
      rom_mem[fidx_r] <= fill_e;
    end
    if (cmd.rom_rd) begin
      rom_q_r <= rom_mem[num_r[AW-1:0]];
    end
  end

  // Spike state
  logic [WEIGHT_BITS-1:0] weight_r;
  logic [TIME_BITS-1:0]   lpre_r, lpost_r, t_r;
  logic                   pre_seen_r, post_seen_r, op_r, needs_r;

  // Event capture: gap to partner and window check
  logic [TIME_BITS+31:0]  t_wide;
  logic [TIME_BITS-1:0]   t_in, dt;
  logic [CW+TIME_BITS-1:0] dt_wide;
  logic [CW-1:0]          dt_c;
  logic                   inwin, seen;

  assign t_wide  = {{TIME_BITS{1'b0}}, in_spike_time};
  assign t_in    = t_wide[TIME_BITS-1:0];
  assign dt      = t_in - (in_op ? lpre_r : lpost_r);
  assign dt_wide = {{CW{1'b0}}, dt};
  assign dt_c    = dt_wide[CW-1:0];
  assign inwin   = (dt_c >= CW'(wlow_r)) && (dt_c <= CW'(whigh_r));
  assign seen    = in_op ? pre_seen_r : post_seen_r;

  // Restoring divider, one quotient bit a cycle; num_r ends as the quotient
  logic [swu_pkg::TAU_W-1:0] rem_r;
  logic [swu_pkg::TAU_W-1:0] tau_sel, tau_eff;
  logic [swu_pkg::TAU_W:0]   rem_sh;
  logic                      ge;

  assign tau_sel = (op_r == swu_pkg::OP_POST) ? ptau_r : dtau_r;
  assign tau_eff = (tau_sel == '0) ? swu_pkg::TAU_W'(1) : tau_sel;
  assign rem_sh  = {rem_r, num_r[swu_pkg::NUM_W-1]};
  assign ge      = rem_sh >= {1'b0, tau_eff};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_op;
      t_r     <= t_in;
      needs_r <= seen && inwin;
      num_r   <= {dt_c[swu_pkg::WIN_W-1:0], 8'd0};
      rem_r   <= '0;
    end else if (cmd.div_step) begin
      rem_r <= ge ? swu_pkg::TAU_W'(rem_sh - {1'b0, tau_eff}) : rem_sh[swu_pkg::TAU_W-1:0];
      num_r <= {num_r[swu_pkg::NUM_W-2:0], ge};
    end
  end

  assign stat.fill_last    = (fidx_r == AW'(EXP_TABLE_DEPTH - 1));
  assign stat.needs_change = needs_r;
  assign stat.q_small      = (num_r < swu_pkg::NUM_W'(EXP_TABLE_DEPTH));

  // Change and agile product
  logic [swu_pkg::GAIN_W-1:0] dw_r;
  logic [swu_pkg::GAIN_W-1:0] gain_sel;
  logic [32:0]                gprod;
  logic [PW-1:0]              prod_r;

  assign gain_sel = (op_r == swu_pkg::OP_POST) ? pgain_r : dgain_r;
  assign gprod    = 33'(gain_sel) * 33'(rom_q_r);

  always_ff @(posedge clk) begin
    if (cmd.dw_zero) begin
      dw_r <= '0;
    end else if (cmd.gain_mul) begin
      dw_r <= gprod[31:16];
    end
    if (cmd.w_mul) begin
      prod_r <= PW'(weight_r) * PW'(17'd65536 - {1'b0, dw_r});
    end
  end

  // Weight update per bound mode
  logic [EW-1:0]          w_ext, dw_ext, sum, agile, wmax_ext, ceil_ext, ceil_eff, w_new;
  logic signed [TXW-1:0]  tx_s;
  logic [swu_pkg::TX_W-1:0]   tx_sat;
  logic [swu_pkg::WNOW_W-1:0] wnow_sat;

  always_comb begin
    w_ext    = EW'(weight_r);
    dw_ext   = EW'(dw_r);
    sum      = w_ext + dw_ext;
    agile    = EW'(prod_r[PW-1:16]);
    wmax_ext = EW'({WEIGHT_BITS{1'b1}});
    ceil_ext = EW'(ceil_r);
    ceil_eff = (ceil_ext > wmax_ext) ? wmax_ext : ceil_ext;
    w_new    = w_ext;
    tx_s     = '0;
    if (op_r == swu_pkg::OP_POST) begin
      case (mode_r)
        swu_pkg::MODE_UNBOUND: w_new = (sum > wmax_ext) ? wmax_ext : sum;
        swu_pkg::MODE_AGILE: begin
          w_new = agile + dw_ext;
          if (w_new > ceil_eff) begin
            w_new = ceil_eff;
          end
        end
        default: w_new = (sum > ceil_eff) ? ceil_eff : sum;
      endcase
    end else begin
      case (mode_r)
        swu_pkg::MODE_UNBOUND: begin
          w_new = w_ext;
          tx_s  = $signed({1'b0, w_ext}) - $signed({1'b0, dw_ext});
        end
        swu_pkg::MODE_AGILE: begin
          w_new = agile;
          tx_s  = $signed({1'b0, agile});
        end
        default: begin
          w_new = (w_ext > dw_ext) ? (w_ext - dw_ext) : '0;
          tx_s  = $signed({1'b0, w_new});
        end
      endcase
    end
    // Saturate to the output formats
    if (!tx_s[TXW-1] && (|tx_s[TXW-2:24])) begin
      tx_sat = {1'b0, {(swu_pkg::TX_W-1){1'b1}}};
    end else if (tx_s[TXW-1] && !(&tx_s[TXW-2:24])) begin
      tx_sat = {1'b1, {(swu_pkg::TX_W-1){1'b0}}};
    end else begin
      tx_sat = tx_s[swu_pkg::TX_W-1:0];
    end
    wnow_sat = (|w_new[EW-1:24]) ? '1 : w_new[swu_pkg::WNOW_W-1:0];
  end

  // State commit and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weight_r    <= WEIGHT_BITS'(32768);
      lpre_r      <= '0;
      lpost_r     <= '0;
      pre_seen_r  <= 1'b0;
      post_seen_r <= 1'b0;
    end else if (cmd.commit) begin
      weight_r <= w_new[WEIGHT_BITS-1:0];
      if (op_r == swu_pkg::OP_POST) begin
        lpost_r     <= t_r;
        post_seen_r <= 1'b1;
      end else begin
        lpre_r     <= t_r;
        pre_seen_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_transmitted <= tx_sat;
      out_weight_now  <= wnow_sat;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/stdp_weight_update_unit.sv =====
// Top level of the pair-based STDP weight update unit.
// Depends on swu_pkg, swu_ctrl and swu_datapath.
//
//  channel | dir | handshake          | word
//  in_     | in  | in_tvalid/tready   | tdata: spike_time; tuser: op
//  out_    | out | out_tvalid/tready  | tdata: transmitted, weight_now
//  cfg_    | in  | cfg_wr_en          | cfg_index, cfg_wdata
//
// After reset the decay table is built, one entry per S_FILL_A/S_FILL_B pass; no word is
// accepted until it is done. Config writes are taken anytime.
// An event runs through capture, check, a divide (one quotient bit a cycle), table read,
// gain multiply, weight multiply and commit before the next word is accepted.
// An event with no partner or outside the window skips the divide and the table read.
// A result waits in the output register; commit stalls while it is not taken.
`default_nettype none
module stdp_weight_update_unit #(
  parameter int TIME_BITS       = 32,
  parameter int WEIGHT_BITS     = 24,
  parameter int EXP_TABLE_DEPTH = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [31:0] spike_time
  input  wire logic        in_tuser,   // [0] op
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [55:0]      out_tdata,  // [24:0] transmitted, [48:25] weight_now, zero pad
  input  wire logic        cfg_wr_en,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [23:0] cfg_wdata
);

  swu_pkg::swu_cmd_t           cmd;
  swu_pkg::swu_stat_t          stat;
  logic [swu_pkg::TX_W-1:0]    tx;
  logic [swu_pkg::WNOW_W-1:0]  wnow;

  swu_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  swu_datapath #(
    .TIME_BITS       (TIME_BITS),
    .WEIGHT_BITS     (WEIGHT_BITS),
    .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_spike_time   (in_tdata),
    .in_op           (in_tuser),
    .cmd             (cmd),
    .stat            (stat),
    .out_transmitted (tx),
    .out_weight_now  (wnow)
  );

  // Pack result word
  assign out_tdata = {7'd0, wnow, tx};

endmodule
`default_nettype wire

// ===== tb/stdp_weight_update_unit_tb.sv =====
// Self-checking testbench for stdp_weight_update_unit: spike words in, weight words out.
// Depends on swu_pkg, RTL; a built-in predictor or typed rows set each expected word.
`timescale 1ns / 1ps
module stdp_weight_update_unit_tb;

  localparam int WATCHDOG_LIMIT = 40000;  // table build plus worst event and stall
  localparam int NUM_PHASES     = 8;
  localparam int WORDS_PER_PHASE = 190;
  localparam int TABLE_DEPTH    = 4096;
  localparam longint unsigned WMAX = 64'hFF_FFFF;

  typedef struct {
    logic                 op;
    logic [31:0]          stamp;
    bit                   fixed;   // expected values typed in below
    logic signed [24:0]   tx;
    logic [23:0]          wnow;
  } spike_row_t;

  typedef struct {
    logic [24:0] tx;
    logic [23:0] wnow;
  } weight_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;
  logic        cfg_wr_en = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [23:0] cfg_wdata = '0;

  stdp_weight_update_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predictor state and register copies
  longint unsigned decay_q16 [TABLE_DEPTH];
  longint unsigned mode_r, pot_gain_r, dep_gain_r, pot_tau_r, dep_tau_r;
  longint unsigned win_lo_r, win_hi_r, ceiling_r;
  longint unsigned syn_weight, last_pre, last_post;
  bit              pre_seen, post_seen;

  weight_word_t expected_words[$];
  int  error_count = 0;
  int  words_checked = 0;
  int  idle_cnt = 0;
  bit  stall_on = 1'b1;
  bit  gaps_on = 1'b1;
  int  stall_left = 0;

  initial begin
    longint unsigned acc;
    acc = 64'd1 << 32;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      decay_q16[i] = (acc + 64'd32768) >> 16;
      acc = (acc * 64'd4278222805) >> 32;
    end
    mode_r = swu_pkg::MODE_HARD; pot_gain_r = 19661; dep_gain_r = 20349;
    pot_tau_r = 20; dep_tau_r = 20; win_lo_r = 2; win_hi_r = 60; ceiling_r = 65536;
    syn_weight = 32768; last_pre = 0; last_post = 0; pre_seen = 0; post_seen = 0;
  end

  // Change size gain*exp(-dt/tau), zero outside the window or past the table
  function automatic longint unsigned decay_change(longint unsigned dt, longint unsigned gain,
                                                   longint unsigned tau);
    longint unsigned idx;
    if (dt < win_lo_r || dt > win_hi_r) return 0;
    if (tau == 0) tau = 1;
    idx = (dt << 8) / tau;
    if (idx >= TABLE_DEPTH) return 0;
    return (gain * decay_q16[idx]) >> 16;
  endfunction

  function automatic weight_word_t apply_spike(logic op, logic [31:0] stamp);
    weight_word_t    res;
    longint unsigned cap, dw, w;
    longint          tx;
    cap = (ceiling_r > WMAX) ? WMAX : ceiling_r;
    dw = 0;
    tx = 0;
    if (op == swu_pkg::OP_POST) begin
      last_post = stamp;
      post_seen = 1;
      if (pre_seen)
        dw = decay_change((stamp - last_pre) & 64'hFFFF_FFFF, pot_gain_r, pot_tau_r);
      if (mode_r == swu_pkg::MODE_UNBOUND) begin
        w = syn_weight + dw;
        syn_weight = (w > WMAX) ? WMAX : w;
      end else if (mode_r == swu_pkg::MODE_AGILE) begin
        w = (syn_weight * (64'd65536 - dw) + dw * 64'd65536) >> 16;
        syn_weight = (w > cap) ? cap : w;
      end else begin
        w = syn_weight + dw;
        syn_weight = (w > cap) ? cap : w;
      end
    end else begin
      last_pre = stamp;
      pre_seen = 1;
      if (post_seen)
        dw = decay_change((stamp - last_post) & 64'hFFFF_FFFF, dep_gain_r, dep_tau_r);
      if (mode_r == swu_pkg::MODE_UNBOUND) begin
        tx = longint'(syn_weight) - longint'(dw);
      end else if (mode_r == swu_pkg::MODE_AGILE) begin
        syn_weight = (syn_weight * (64'd65536 - dw)) >> 16;
        tx = longint'(syn_weight);
      end else begin
        syn_weight = (syn_weight > dw) ? syn_weight - dw : 0;
        tx = longint'(syn_weight);
      end
    end
    if (tx > 16777215) tx = 16777215;
    if (tx < -16777216) tx = -16777216;
    res.tx = tx[24:0];
    res.wnow = syn_weight[23:0];
    return res;
  endfunction

  // Register write; caller drops the enable after the last one
  task automatic write_reg(logic [2:0] idx, logic [23:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      swu_pkg::REG_BOUND_MODE: mode_r     = val[1:0];
      swu_pkg::REG_POT_GAIN:   pot_gain_r = val[15:0];
      swu_pkg::REG_DEP_GAIN:   dep_gain_r = val[15:0];
      swu_pkg::REG_POT_TAU:    pot_tau_r  = val[15:0];
      swu_pkg::REG_DEP_TAU:    dep_tau_r  = val[15:0];
      swu_pkg::REG_WIN_LOW:    win_lo_r   = val[19:0];
      swu_pkg::REG_WIN_HIGH:   win_hi_r   = val[19:0];
      default:                 ceiling_r  = val;
    endcase
  endtask

  // Send one spike word; expectation is queued at the accepting edge
  task automatic send_spike(logic op, logic [31:0] stamp, bit fixed, weight_word_t typed);
    weight_word_t pred;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= stamp;
    in_tuser  <= op;
    do @(posedge clk); while (!in_tready);
    pred = apply_spike(op, stamp);
    expected_words.insert(expected_words.size(), fixed ? typed : pred);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // Receiver stalls in random bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (stall_on && $urandom_range(0, 7) == 0) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(0, 15);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Result checker
  always @(posedge clk) begin
    weight_word_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_words.size() == 0) begin
        $error("unexpected result word %h", out_tdata);
        error_count++;
      end else begin
        want = expected_words.pop_front();
        words_checked++;
        if (out_tdata[24:0] !== want.tx) begin
          $error("transmitted: expected %h, got %h", want.tx, out_tdata[24:0]);
          error_count++;
        end
        if (out_tdata[48:25] !== want.wnow) begin
          $error("weight_now: expected %h, got %h", want.wnow, out_tdata[48:25]);
          error_count++;
        end
        if (out_tdata[55:49] !== '0) begin
          $error("pad: expected 0, got %h", out_tdata[55:49]);
          error_count++;
        end
      end
    end
  end

  // Watchdog on cycles without any accepted word
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cnt <= 0;
    end else if (idle_cnt >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
  end

  // Directed words at reset settings
  spike_row_t directed [] = '{
    '{swu_pkg::OP_POST, 32'h0000_0000, 1, 25'sd0,     24'd32768},  // no pre partner yet
    '{swu_pkg::OP_PRE,  32'hFFFF_FFFF, 1, 25'sd32768, 24'd32768},  // gap far outside window
    '{swu_pkg::OP_POST, 32'h0000_0003, 0, 25'sd0, 24'd0},          // gap wraps through zero
    '{swu_pkg::OP_PRE,  32'h0000_0004, 0, 25'sd0, 24'd0},          // gap below window
    '{swu_pkg::OP_PRE,  32'h0000_0005, 0, 25'sd0, 24'd0},
    '{swu_pkg::OP_POST, 32'h0000_0007, 0, 25'sd0, 24'd0},          // window low edge
    '{swu_pkg::OP_PRE,  32'h0000_0043, 0, 25'sd0, 24'd0},          // window high edge
    '{swu_pkg::OP_POST, 32'h0000_0080, 0, 25'sd0, 24'd0},
    '{swu_pkg::OP_POST, 32'hAAAA_AAAA, 0, 25'sd0, 24'd0},
    '{swu_pkg::OP_PRE,  32'h5555_5555, 0, 25'sd0, 24'd0},
    '{swu_pkg::OP_PRE,  32'h5555_5565, 0, 25'sd0, 24'd0},
    '{swu_pkg::OP_POST, 32'h5555_5570, 0, 25'sd0, 24'd0},
    '{swu_pkg::OP_POST, 32'h5555_5571, 0, 25'sd0, 24'd0},
    '{swu_pkg::OP_PRE,  32'h5555_5575, 0, 25'sd0, 24'd0}
  };

  initial begin
    weight_word_t    typed;
    longint unsigned now_t, step_max;
    logic            op;
    int              total_words;
    total_words = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) begin
      typed.tx = directed[i].tx;
      typed.wnow = directed[i].wnow;
      send_spike(directed[i].op, directed[i].stamp, directed[i].fixed, typed);
      total_words++;
    end
    drain();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      // Phase settings: extremes on some phases, random on others
      write_reg(swu_pkg::REG_BOUND_MODE, 24'(ph % 4));
      write_reg(swu_pkg::REG_POT_GAIN,
                24'(ph == 1 ? 16'hFFFF : ph == 2 ? 16'h0 : $urandom_range(0, 65535)));
      write_reg(swu_pkg::REG_DEP_GAIN,
                24'(ph == 1 ? 16'hFFFF : ph == 2 ? 16'h0 : $urandom_range(0, 65535)));
      write_reg(swu_pkg::REG_POT_TAU,
                24'(ph == 1 ? 16'd1 : ph == 5 ? 16'hFFFF : $urandom_range(1, 64)));
      write_reg(swu_pkg::REG_DEP_TAU,
                24'(ph == 1 ? 16'd0 : ph == 5 ? 16'hFFFF : $urandom_range(1, 64)));
      write_reg(swu_pkg::REG_WIN_LOW,
                24'(ph == 1 ? 20'd0 : ph == 3 ? 20'd50 : $urandom_range(0, 4)));
      write_reg(swu_pkg::REG_WIN_HIGH,
                24'(ph == 1 ? 20'hFFFFF : ph == 3 ? 20'd10 : $urandom_range(20, 200)));
      write_reg(swu_pkg::REG_CEILING, 24'(ph == 0 ? 24'd0 : ph == 1 ? 24'hFFFFFF :
                ph == 6 ? 24'd1000 : $urandom_range(1 << 14, (1 << 24) - 1)));
      cfg_wr_en <= 1'b0;
      @(posedge clk);

      if (ph == NUM_PHASES - 1) begin
        gaps_on = 0;
        stall_on = 0;
      end
      step_max = ((win_hi_r > 400) ? 400 : win_hi_r) + 20;
      now_t = $urandom;
      for (int k = 0; k < WORDS_PER_PHASE; k++) begin
        // Mostly gaps near the window, some wild jumps
        if ($urandom_range(0, 19) == 0) now_t = $urandom;
        else now_t = now_t + $urandom_range(0, step_max);
        op = 1'($urandom_range(0, 1));
        send_spike(op, now_t[31:0], 0, typed);
        total_words++;
      end
      drain();
    end

    $display("Sent %0d spike words over %0d register settings; %0d result words checked.",
             total_words, NUM_PHASES + 1, words_checked);
    $display("Covered all bound modes, wrapped gaps, window edges and gain/tau extremes.");
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
